// File: rtl/core/cdu_pkg.sv
// Shared types, constants and month tables for the calendar date unit.
package cdu_pkg;

  localparam int unsigned DAY_W = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W = 15;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned QUOT_W = 9;
  localparam int unsigned LEAPS_W = 14;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 15'd1900;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 15'd30000;

  // Reciprocal of 100 scaled by 2^19; exact for every 15-bit year.
  localparam int unsigned RECIP100_W = 13;
  localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
  localparam int unsigned RECIP100_SHIFT = 19;
  localparam int unsigned PROD_W = YEAR_W + RECIP100_W;

  localparam logic [MONTH_W-1:0] JANUARY = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
  localparam logic [DAY_W-1:0] DEC_DAYS = 5'd31;

  typedef enum logic [1:0] {
    OP_VALIDATE = 2'd0,
    OP_NEXT     = 2'd1,
    OP_PREV     = 2'd2,
    OP_DIFF     = 2'd3
  } op_e;

  typedef enum logic {
    REG_MIN_YEAR = 1'b0,
    REG_MAX_YEAR = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic sel_b;
    logic div_en;
    logic chk_en;
    logic num_en;
    logic finish;
  } cdu_cmd_t;

  typedef struct packed {
    op_e op;
  } cdu_status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/calendar_date_unit.sv
// Top level of the calendar date unit: controller, datapath and configuration port.
// Validate, next and previous raise done_o after the divide, check and finish steps of the sequencer.
// Difference raises done_o after adding the number step for the first date and divide, check and number for the second.
// A new word is taken only when the sequencer is idle again; start_i is ignored while busy_o is high.
// The result is shown for one cycle on done_o and the receiver cannot stall it.
// Reset clears the sequencer and strobe and sets the year limits to 1900 and 30000.
module calendar_date_unit import cdu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [DAY_W-1:0]   day_a_i,
  input  logic [MONTH_W-1:0] month_a_i,
  input  logic [YEAR_W-1:0]  year_a_i,
  input  logic [DAY_W-1:0]   day_b_i,
  input  logic [MONTH_W-1:0] month_b_i,
  input  logic [YEAR_W-1:0]  year_b_i,
  output logic               done_o,
  output logic               valid_res_o,
  output logic [DAY_W-1:0]   day_out_o,
  output logic [MONTH_W-1:0] month_out_o,
  output logic [YEAR_W-1:0]  year_out_o,
  output logic [COUNT_W-1:0] day_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [YEAR_W-1:0]  cfg_data_i
);

  cdu_cmd_t    cmd;
  cdu_status_t status;
  logic        start_acc;

  assign cfg_ready_o = 1'b1;
  assign start_acc   = start_i && !busy_o;

  cdu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_acc),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  cdu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (op_i),
    .day_a_i     (day_a_i),
    .month_a_i   (month_a_i),
    .year_a_i    (year_a_i),
    .day_b_i     (day_b_i),
    .month_b_i   (month_b_i),
    .year_b_i    (year_b_i),
    .done_o      (done_o),
    .valid_res_o (valid_res_o),
    .day_out_o   (day_out_o),
    .month_out_o (month_out_o),
    .year_out_o  (year_out_o),
    .day_count_o (day_count_o)
  );

endmodule

// File: rtl/core/cdu_ctrl.sv
// Sequencing state machine for the calendar date unit.
module cdu_ctrl import cdu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  cdu_status_t status_i,
  output cdu_cmd_t    cmd_o,
  output logic        busy_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV_A  = 8'b0000_0010,
    S_CHK_A  = 8'b0000_0100,
    S_NUM_A  = 8'b0000_1000,
    S_DIV_B  = 8'b0001_0000,
    S_CHK_B  = 8'b0010_0000,
    S_NUM_B  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
        if (start_i) begin
          state_d = S_DIV_A;
        end
      end
      S_DIV_A: begin
        cmd_o.div_en = 1'b1;
        state_d = S_CHK_A;
      end
      S_CHK_A: begin
        cmd_o.chk_en = 1'b1;
        state_d = (status_i.op == OP_DIFF) ? S_NUM_A : S_FINISH;
      end
      S_NUM_A: begin
        cmd_o.num_en = 1'b1;
        state_d = S_DIV_B;
      end
      S_DIV_B: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.div_en = 1'b1;
        state_d = S_CHK_B;
      end
      S_CHK_B: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.chk_en = 1'b1;
        state_d = S_NUM_B;
      end
      S_NUM_B: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.num_en = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/core/cdu_datapath.sv
// Datapath of the calendar date unit: year limits, leap test, day numbers and results.
module cdu_datapath import cdu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdu_cmd_t           cmd_i,
  output cdu_status_t        status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [YEAR_W-1:0]  cfg_data_i,
  input  logic [1:0]         op_i,
  input  logic [DAY_W-1:0]   day_a_i,
  input  logic [MONTH_W-1:0] month_a_i,
  input  logic [YEAR_W-1:0]  year_a_i,
  input  logic [DAY_W-1:0]   day_b_i,
  input  logic [MONTH_W-1:0] month_b_i,
  input  logic [YEAR_W-1:0]  year_b_i,
  output logic               done_o,
  output logic               valid_res_o,
  output logic [DAY_W-1:0]   day_out_o,
  output logic [MONTH_W-1:0] month_out_o,
  output logic [YEAR_W-1:0]  year_out_o,
  output logic [COUNT_W-1:0] day_count_o
);

  logic [YEAR_W-1:0] min_year_q, max_year_q;

  op_e               op_q;
  logic [DAY_W-1:0]   da_q, db_q;
  logic [MONTH_W-1:0] ma_q, mb_q;
  logic [YEAR_W-1:0]  ya_q, yb_q;

  logic [QUOT_W-1:0]  quot_q;
  logic [COUNT_W-1:0] y365_q;
  logic [LEAPS_W-1:0] leaps_q;
  logic               leap_q, leap_a_q;
  logic               ok_a_q, ok_b_q;
  logic [DAY_W-1:0]   mlen_a_q;
  logic [COUNT_W-1:0] na_q, nb_q;

  logic               done_q;
  logic               valid_q;
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;
  logic [COUNT_W-1:0] count_q;

  logic [DAY_W-1:0]   d_sel;
  logic [MONTH_W-1:0] m_sel;
  logic [YEAR_W-1:0]  y_sel;
  logic [PROD_W-1:0]  prod;
  logic [YEAR_W-1:0]  rem;
  logic               rem_zero;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               ok;
  logic [YEAR_W:0]    ysum;
  logic [QUOT_W:0]    c100;
  logic [QUOT_W:0]    c400;
  logic [LEAPS_W-1:0] leaps;
  logic [COUNT_W-1:0] dnum;

  logic               valid_d;
  logic [DAY_W-1:0]   day_d;
  logic [MONTH_W-1:0] month_d;
  logic [YEAR_W-1:0]  year_d;
  logic [COUNT_W-1:0] count_d;

  assign status_o.op = op_q;

  assign d_sel = cmd_i.sel_b ? db_q : da_q;
  assign m_sel = cmd_i.sel_b ? mb_q : ma_q;
  assign y_sel = cmd_i.sel_b ? yb_q : ya_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RST;
      max_year_q <= MAX_YEAR_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MIN_YEAR: min_year_q <= cfg_data_i;
        REG_MAX_YEAR: max_year_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(op_i);
      da_q <= day_a_i;
      ma_q <= month_a_i;
      ya_q <= year_a_i;
      db_q <= day_b_i;
      mb_q <= month_b_i;
      yb_q <= year_b_i;
    end
  end

  // Year divided by 100 through the scaled reciprocal, and 365 times the year.
  assign prod = PROD_W'(y_sel) * PROD_W'(RECIP100);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_en) begin
      quot_q <= prod[RECIP100_SHIFT +: QUOT_W];
      y365_q <= COUNT_W'(y_sel) * COUNT_W'(365);
    end
  end

  // Leap test, date check and leap days before the year.
  assign rem      = y_sel - (YEAR_W'(quot_q) * YEAR_W'(100));
  assign rem_zero = (rem == '0);
  assign leap     = rem_zero ? (quot_q[1:0] == 2'b00) : (y_sel[1:0] == 2'b00);
  assign mlen     = month_len(m_sel, leap);
  assign ok       = (y_sel >= min_year_q) && (y_sel <= max_year_q) &&
                    (m_sel >= JANUARY) && (m_sel <= DECEMBER) &&
                    (d_sel != '0) && (d_sel <= mlen);
  assign ysum     = {1'b0, y_sel} + (YEAR_W+1)'(3);
  assign c100     = {1'b0, quot_q} + (QUOT_W+1)'(!rem_zero);
  assign c400     = (c100 + (QUOT_W+1)'(3)) >> 2;
  assign leaps    = ysum[YEAR_W:2] - LEAPS_W'(c100) + LEAPS_W'(c400);

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_en) begin
      leap_q  <= leap;
      leaps_q <= leaps;
      if (cmd_i.sel_b) begin
        ok_b_q <= ok;
      end else begin
        ok_a_q   <= ok;
        leap_a_q <= leap;
        mlen_a_q <= mlen;
      end
    end
  end

  assign dnum = y365_q + COUNT_W'(leaps_q) + COUNT_W'(days_before(m_sel)) +
                COUNT_W'(d_sel) - COUNT_W'(1) +
                COUNT_W'((m_sel > FEBRUARY) && leap_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.num_en) begin
      if (cmd_i.sel_b) begin
        nb_q <= dnum;
      end else begin
        na_q <= dnum;
      end
    end
  end

  always_comb begin
    valid_d = 1'b0;
    day_d   = '0;
    month_d = '0;
    year_d  = '0;
    count_d = '0;
    unique case (op_q)
      OP_VALIDATE: begin
        valid_d = ok_a_q;
      end
      OP_NEXT: begin
        if (ok_a_q) begin
          valid_d = 1'b1;
          if (da_q == mlen_a_q) begin
            day_d = DAY_W'(1);
            if (ma_q == DECEMBER) begin
              month_d = JANUARY;
              year_d  = ya_q + YEAR_W'(1);
            end else begin
              month_d = ma_q + MONTH_W'(1);
              year_d  = ya_q;
            end
          end else begin
            day_d   = da_q + DAY_W'(1);
            month_d = ma_q;
            year_d  = ya_q;
          end
        end
      end
      OP_PREV: begin
        if (ok_a_q) begin
          valid_d = 1'b1;
          if (da_q == DAY_W'(1)) begin
            if (ma_q == JANUARY) begin
              day_d   = DEC_DAYS;
              month_d = DECEMBER;
              year_d  = ya_q - YEAR_W'(1);
            end else begin
              day_d   = month_len(ma_q - MONTH_W'(1), leap_a_q);
              month_d = ma_q - MONTH_W'(1);
              year_d  = ya_q;
            end
          end else begin
            day_d   = da_q - DAY_W'(1);
            month_d = ma_q;
            year_d  = ya_q;
          end
        end
      end
      OP_DIFF: begin
        if (ok_a_q && ok_b_q) begin
          valid_d = 1'b1;
          count_d = (na_q > nb_q) ? (na_q - nb_q) : (nb_q - na_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      valid_q <= valid_d;
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      count_q <= count_d;
    end
  end

  assign done_o      = done_q;
  assign valid_res_o = valid_q;
  assign day_out_o   = day_q;
  assign month_out_o = month_q;
  assign year_out_o  = year_q;
  assign day_count_o = count_q;

  a_done_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> done_q)
    else $error("Result strobe missing after the finish step.");

  a_done_only_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.finish))
    else $error("Result strobe without a finish step.");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !valid_q) |->
      (day_q == '0 && month_q == '0 && year_q == '0 && count_q == '0))
    else $error("Invalid result carries nonzero fields.");

  a_second_date_only_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sel_b && cmd_i.num_en) |-> (op_q == OP_DIFF))
    else $error("Second date processed for an operation other than difference.");

  a_step_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && valid_q && (op_q == OP_NEXT || op_q == OP_PREV)) |->
      (month_q >= JANUARY && month_q <= DECEMBER && day_q != '0))
    else $error("Stepped date out of range.");

endmodule
